// File: rtl/core/spsf_pkg.sv
// ----------------------------------------------------------------------------
// Pencil sketch filter package
// Shared constants, types and the queue entry format.
// ----------------------------------------------------------------------------
package spsf_pkg;
	localparam int MaxWidth  = 2048;
	localparam int MaxHeight = 2048;
	localparam int ColW  = $clog2(MaxWidth);
	localparam int DimW  = 12;
	localparam int SlotW = $clog2(MaxWidth + 1);
	localparam int PosW  = $clog2(MaxWidth * MaxHeight + 1);
	localparam int LumaW = 16;
	localparam int ThrMax  = 65280;
	localparam int DarkMax = 256;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_THRESH = 2'd2;
	localparam logic [1:0] REG_DARK   = 2'd3;

	typedef struct packed {
		logic [LumaW-1:0] w0, w1, w2, w3, w5, w6, w7, w8;
		logic [31:0]      pix;
		logic             interior;
		logic             frame_end;
	} job_t;

	typedef struct packed {
		logic [15:0] thresh;
		logic [8:0]  dark;
	} gain_t;
endpackage

// File: rtl/core/spsf_front.sv
// ----------------------------------------------------------------------------
// Pencil sketch front end
// Accepts items, keeps line buffers, delay line and window, and issues jobs.
// ----------------------------------------------------------------------------
module spsf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             restart,
	input  logic [11:0]      eff_w,
	input  logic [11:0]      eff_h,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_drain,
	input  logic [31:0]      in_pix,
	output logic             job_valid,
	output spsf_pkg::job_t   job,
	input  logic             q_ready
);
	import spsf_pkg::*;

	logic [LumaW-1:0] luma_mem [0:2*MaxWidth-1];
	logic [31:0]      delay_mem [0:MaxWidth];
	logic [LumaW-1:0] win_q [0:8];
	logic [ColW:0]    col_q;
	logic [DimW:0]    row_q;
	logic [PosW-1:0]  taken_q, outpos_q;
	logic [SlotW-1:0] wr_q, rd_q;
	logic [LumaW-1:0] older_q, newer_q;
	logic             rd_wait_q;
	logic [PosW-1:0]  total;
	logic             acc, is_pix, is_drain, emit, frame_done;
	logic [LumaW-1:0] luma;
	logic [ColW-1:0]  col;
	logic [SlotW-1:0] wr_nx, rd_nx;

	assign total = PosW'(eff_w) * PosW'(eff_h);
	// The line buffer read for a new position is registered, so a pixel is
	// taken only once that read has settled.
	assign in_ready = q_ready && !rd_wait_q;
	assign acc = in_valid && in_ready;
	assign is_pix = acc && !in_drain && row_q < (DimW+1)'(eff_h);
	assign is_drain = acc && in_drain && row_q >= (DimW+1)'(eff_h)
		&& outpos_q < total;
	assign frame_done = is_drain && outpos_q + 1'b1 >= total;
	assign emit = is_drain || (is_pix && taken_q >= PosW'(eff_w) + 1'b1);
	assign luma = LumaW'(16'd77 * in_pix[7:0] + 16'd150 * in_pix[15:8]
		+ 16'd29 * in_pix[23:16]);
	assign col = col_q[ColW-1:0];
	assign wr_nx = (wr_q + 1'b1 >= SlotW'(eff_w) + 1'b1) ? '0 : wr_q + 1'b1;
	assign rd_nx = (rd_q + 1'b1 >= SlotW'(eff_w) + 1'b1) ? '0 : rd_q + 1'b1;

	always_ff @(posedge clk) begin
		if (is_pix) begin
			luma_mem[{row_q[0], col}] <= luma;
			delay_mem[wr_q] <= in_pix;
		end
		older_q <= luma_mem[{row_q[0], col}];
		newer_q <= luma_mem[{~row_q[0], col}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0; row_q <= '0; taken_q <= '0; outpos_q <= '0;
			wr_q <= '0; rd_q <= '0; job_valid <= 1'b0; rd_wait_q <= 1'b1;
			for (int k = 0; k < 9; k++) win_q[k] <= '0;
		end else begin
			job_valid <= q_ready ? emit : job_valid;
			rd_wait_q <= is_pix || restart || frame_done;
			if (restart || frame_done) begin
				col_q <= '0; row_q <= '0; taken_q <= '0; outpos_q <= '0;
				wr_q <= '0; rd_q <= '0;
				for (int k = 0; k < 9; k++) win_q[k] <= '0;
			end else begin
				if (emit) begin
					rd_q <= rd_nx;
					outpos_q <= outpos_q + 1'b1;
				end
				if (is_pix) begin
					for (int k = 0; k < 3; k++) begin
						win_q[k*3]   <= win_q[k*3+1];
						win_q[k*3+1] <= win_q[k*3+2];
					end
					win_q[2] <= older_q; win_q[5] <= newer_q; win_q[8] <= luma;
					wr_q <= wr_nx;
					taken_q <= taken_q + 1'b1;
					if (col_q + 1'b1 >= (ColW+1)'(eff_w)) begin
						col_q <= '0; row_q <= row_q + 1'b1;
					end else col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit && q_ready) begin
			job.pix <= delay_mem[rd_q];
			job.interior <= is_pix && row_q >= 2 && col_q >= 2;
			job.frame_end <= outpos_q + 1'b1 == total;
			job.w0 <= win_q[1]; job.w1 <= win_q[2]; job.w2 <= older_q;
			job.w3 <= win_q[4]; job.w5 <= newer_q;
			job.w6 <= win_q[7]; job.w7 <= win_q[8]; job.w8 <= luma;
		end
	end
endmodule

// File: rtl/core/spsf_queue.sv
// ----------------------------------------------------------------------------
// Pencil sketch job queue
// Short queue between the front end and the edge pipeline.
// ----------------------------------------------------------------------------
module spsf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	input  spsf_pkg::job_t wr_data,
	output logic           space,
	output logic           rd_valid,
	output spsf_pkg::job_t rd_data,
	input  logic           rd_ready
);
	import spsf_pkg::*;

	job_t       mem_q [0:3];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       push, pop;

	assign rd_valid = cnt_q != 0;
	assign rd_data = mem_q[rp_q];
	assign pop = rd_valid && rd_ready;
	assign push = wr_valid && (cnt_q < 4 || pop);
	// Two slots kept for the job in flight in the front end.
	assign space = cnt_q < 3'd2;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("queue overfilled");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q == 0 |-> !pop)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q == 4 && !pop |-> !wr_valid)
		else $error("job lost at full queue");
endmodule

// File: rtl/core/spsf_back.sv
// ----------------------------------------------------------------------------
// Pencil sketch back end
// Sobel magnitude, sequential square root and division, grey output.
// ----------------------------------------------------------------------------
module spsf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  spsf_pkg::gain_t gain,
	input  logic           job_valid,
	input  spsf_pkg::job_t job,
	output logic           job_ready,
	output logic           out_valid,
	output logic [31:0]    out_pix,
	output logic           out_last,
	input  logic           out_ready
);
	import spsf_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MAG  = 3'd1;
	localparam logic [2:0] ST_SQRT = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_GREY = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]  st_q;
	logic [4:0]  cnt_q;
	job_t        job_q;
	logic [37:0] s_q, rem_q;
	logic [18:0] root_q;
	logic [35:0] num_q;
	logic [16:0] q_q;
	logic [15:0] den_q;
	logic [39:0] sq_tr;
	logic [18:0] root_nx;
	logic signed [20:0] gx, gy;
	logic [31:0] tt;
	logic [33:0] prod;
	logic [7:0]  grey;

	assign gx = 21'(job.w2) + 21'(job.w5) * 21'd2 + 21'(job.w8)
		- 21'(job.w0) - 21'(job.w3) * 21'd2 - 21'(job.w6);
	assign gy = 21'(job.w6) + 21'(job.w7) * 21'd2 + 21'(job.w8)
		- 21'(job.w0) - 21'(job.w1) * 21'd2 - 21'(job.w2);
	assign tt = gain.thresh > 16'(ThrMax) ? 32'(ThrMax) * 32'(ThrMax)
		: 32'(gain.thresh) * 32'(gain.thresh);
	assign job_ready = st_q == ST_IDLE;
	assign out_valid = st_q == ST_OUT;
	assign sq_tr = {rem_q[37:0], s_q[37:36]} - {root_q, 2'b01};
	assign root_nx = {root_q[17:0], ~sq_tr[39]};
	assign prod = 34'(q_q) * 34'(gain.dark > 9'(DarkMax) ? 9'(DarkMax) : gain.dark);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else begin
			case (st_q)
				ST_IDLE: if (job_valid) st_q <= job.interior ? ST_MAG : ST_OUT;
				ST_MAG:  st_q <= (s_q > 38'(tt)) ? ST_GREY : ST_SQRT;
				ST_SQRT: if (cnt_q == 0) st_q <= ST_DIV;
				ST_DIV:  if (cnt_q == 0) st_q <= ST_GREY;
				ST_GREY: st_q <= ST_OUT;
				ST_OUT:  if (out_ready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				job_q <= job;
				s_q <= 38'(gx * gx) + 38'(gy * gy);
				q_q <= '0;
			end
			ST_MAG: begin
				if (s_q > 38'(tt)) q_q <= 17'd65536;
				rem_q <= '0; root_q <= '0; cnt_q <= 5'd18;
				den_q <= gain.thresh > 16'(ThrMax) ? 16'(ThrMax)
					: (gain.thresh < 16'd256 ? 16'd256 : gain.thresh);
			end
			ST_SQRT: begin
				s_q <= s_q << 2;
				root_q <= root_nx;
				if (!sq_tr[39]) rem_q <= sq_tr[37:0];
				else rem_q <= {rem_q[35:0], s_q[37:36]};
				if (cnt_q == 0) begin
					// The root is at most the denominator, so half of it starts
					// below the denominator and the quotient fits 17 bits.
					num_q <= 36'(root_nx[18:1]); cnt_q <= 5'd16;
					s_q <= 38'({root_nx[0], 34'd0});
				end else cnt_q <= cnt_q - 1'b1;
			end
			ST_DIV: begin
				// Restoring division of root * 65536 by the denominator.
				s_q <= s_q << 1;
				if ({num_q[35:0], s_q[34]} >= 37'(den_q)) begin
					num_q <= 36'({num_q[35:0], s_q[34]} - 37'(den_q));
					q_q <= {q_q[15:0], 1'b1};
				end else begin
					num_q <= {num_q[34:0], s_q[34]};
					q_q <= {q_q[15:0], 1'b0};
				end
				if (cnt_q == 0) begin
					if ({q_q[15:0], 1'b1} > 17'd65536 &&
						{num_q[35:0], s_q[34]} >= 37'(den_q)) q_q <= 17'd65536;
				end else cnt_q <= cnt_q - 1'b1;
			end
			ST_GREY: begin
				job_q.pix[23:0] <= {3{grey}};
			end
			default: ;
		endcase
	end

	always_comb begin
		logic [41:0] n;
		n = (42'd255 << 24) - 42'd255 * 42'(prod) + (42'd1 << 23);
		grey = n[41:24] > 18'd255 ? 8'd255 : n[31:24];
		if (q_q > 17'd65536) grey = 8'd0;
	end

	assign out_pix = job_q.pix;
	assign out_last = job_q.frame_end;

	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !job_ready)
		else $error("output and intake overlap");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pix))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n) st_q == ST_GREY |=> out_valid)
		else $error("grey not presented");
endmodule

// File: rtl/core/sobel_pencil_sketch_filter_top.sv
// Border and drain items go straight to the output. Interior items above the
// threshold skip the root; other interior items take a 19-step square root
// and a 17-step divide. The input waits on a registered line buffer read after
// each pixel; the back end takes no new job until its result is taken.
// Reset is asynchronous and active low; line and delay memories are not cleared.
// ----------------------------------------------------------------------------
// Pencil sketch filter top level
// Configuration registers, front end, queue and back end.
// ----------------------------------------------------------------------------
module sobel_pencil_sketch_filter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // in_red, in_green, in_blue, in_alpha
	input  logic        s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // out_red, out_green, out_blue, out_alpha
	output logic        m_tlast   // frame_end
);
	import spsf_pkg::*;

	logic [11:0] width_q, height_q, eff_w, eff_h;
	gain_t       gain_q;
	logic        wr, restart, jv, space, qv, qr;
	job_t        jb, qd;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign restart = wr && (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT);
	assign eff_w = width_q == 0 ? 12'd1 : (width_q > 12'(MaxWidth) ? 12'(MaxWidth) : width_q);
	assign eff_h = height_q == 0 ? 12'd1 : (height_q > 12'(MaxHeight) ? 12'(MaxHeight) : height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 12'd640; height_q <= 12'd480;
			gain_q.thresh <= 16'd32640; gain_q.dark <= 9'd256;
		end else if (wr) begin
			case (paddr[3:2])
				REG_WIDTH:  width_q <= pwdata[11:0];
				REG_HEIGHT: height_q <= pwdata[11:0];
				REG_THRESH: gain_q.thresh <= pwdata[15:0];
				REG_DARK:   gain_q.dark <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			REG_THRESH: prdata = 32'(gain_q.thresh);
			REG_DARK:   prdata = 32'(gain_q.dark);
			default:    prdata = '0;
		endcase
	end

	spsf_front u_front (.clk, .arst_n, .restart,
		.eff_w, .eff_h, .in_valid(s_tvalid), .in_ready(s_tready), .in_drain(s_tuser),
		.in_pix(s_tdata), .job_valid(jv), .job(jb), .q_ready(space));

	spsf_queue u_queue (.clk, .arst_n, .wr_valid(jv && space), .wr_data(jb), .space,
		.rd_valid(qv), .rd_data(qd), .rd_ready(qr));

	spsf_back u_back (.clk, .arst_n, .gain(gain_q), .job_valid(qv), .job(qd),
		.job_ready(qr), .out_valid(m_tvalid), .out_pix(m_tdata), .out_last(m_tlast),
		.out_ready(m_tready));
endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pencil sketch filter testbench
// Streams whole frames, drain ticks and stray items through the filter under
// varying geometry, threshold and darkness. Every accepted input item is fed
// to a bit-exact predictor, and each output item is checked in order.
// ----------------------------------------------------------------------------
import spsf_pkg::*;

class sketch_scoreboard;
	typedef struct {
		bit [31:0] data;
		bit        last;
	} pixel_out_t;

	bit [11:0]   width_reg, height_reg;
	bit [15:0]   thresh_reg;
	bit [8:0]    dark_reg;
	bit [15:0]   luma_mem [2*MaxWidth];
	bit [31:0]   pix_mem [MaxWidth+1];
	bit [15:0]   win [9];
	int unsigned col, row, out_pos, wr_ptr, rd_ptr;
	pixel_out_t  pending [$];
	int          errors;

	function new();
		width_reg  = 640;
		height_reg = 480;
		thresh_reg = 32640;
		dark_reg   = 256;
		errors     = 0;
		restart();
	endfunction

	function void restart();
		foreach (win[k]) win[k] = 0;
		col = 0; row = 0; out_pos = 0; wr_ptr = 0; rd_ptr = 0;
	endfunction

	function void set_reg(logic [1:0] idx, bit [31:0] v);
		case (idx)
			REG_WIDTH: begin
				width_reg = v[11:0];
				restart();
			end
			REG_HEIGHT: begin
				height_reg = v[11:0];
				restart();
			end
			REG_THRESH: thresh_reg = v[15:0];
			REG_DARK:   dark_reg = v[8:0];
			default: ;
		endcase
	endfunction

	function int unsigned eff_w();
		if (width_reg == 0) return 1;
		return (width_reg > MaxWidth) ? MaxWidth : width_reg;
	endfunction

	function int unsigned eff_h();
		if (height_reg == 0) return 1;
		return (height_reg > MaxHeight) ? MaxHeight : height_reg;
	endfunction

	function bit [7:0] sketch_grey();
		longint gx, gy;
		longint unsigned s, t, d, den, edge_q, num, r, b, v;
		gx = (longint'(win[2]) + 2*win[5] + win[8]) - (longint'(win[0]) + 2*win[3] + win[6]);
		gy = (longint'(win[6]) + 2*win[7] + win[8]) - (longint'(win[0]) + 2*win[1] + win[2]);
		s = gx*gx + gy*gy;
		t = (thresh_reg > ThrMax) ? ThrMax : thresh_reg;
		d = (dark_reg > DarkMax) ? DarkMax : dark_reg;
		if (s > t*t) begin
			edge_q = 65536;
		end else begin
			v = s; r = 0; b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			den = (t < 256) ? 256 : t;
			edge_q = (r << 16) / den;
			if (edge_q > 65536) edge_q = 65536;
		end
		num = (64'd255 << 24) - 255*edge_q*d + (64'd1 << 23);
		num = num >> 24;
		return (num > 255) ? 8'd255 : num[7:0];
	endfunction

	function void emit(bit interior, int unsigned w, int unsigned total);
		pixel_out_t e;
		bit [31:0]  pix;
		bit [7:0]   g;
		pix = pix_mem[rd_ptr];
		if (interior) begin
			g = sketch_grey();
			e.data = {pix[31:24], g, g, g};
		end else begin
			e.data = pix;
		end
		e.last = (out_pos + 1 == total);
		pending.push_back(e);
		rd_ptr = (rd_ptr + 1 >= w + 1) ? 0 : rd_ptr + 1;
		out_pos++;
	endfunction

	function void note_input(bit drain, bit [31:0] d);
		int unsigned w, h, total, c;
		bit [15:0]   luma, older, newer;
		w = eff_w();
		h = eff_h();
		total = w * h;
		if (drain) begin
			if (row < h || out_pos >= total) return;
			emit(1'b0, w, total);
			if (out_pos >= total) restart();
			return;
		end
		if (row >= h) return;
		luma = 77*d[7:0] + 150*d[15:8] + 29*d[23:16];
		c = col % MaxWidth;
		older = luma_mem[(row & 1)*MaxWidth + c];
		newer = luma_mem[((row & 1) ^ 1)*MaxWidth + c];
		for (int k = 0; k < 3; k++) begin
			win[k*3]   = win[k*3+1];
			win[k*3+1] = win[k*3+2];
		end
		win[2] = older;
		win[5] = newer;
		win[8] = luma;
		luma_mem[(row & 1)*MaxWidth + c] = luma;
		if (row*w + col >= w + 1) emit(row >= 2 && col >= 2, w, total);
		pix_mem[wr_ptr] = d;
		wr_ptr = (wr_ptr + 1 >= w + 1) ? 0 : wr_ptr + 1;
		col++;
		if (col >= w) begin
			col = 0;
			row++;
		end
	endfunction

	function void check_output(bit [31:0] d, bit last);
		pixel_out_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected item expected none actual data=%h last=%b", $time, d, last);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (e.data != d || e.last != last) begin
			$display("%0t: mismatch expected data=%h last=%b actual data=%h last=%b",
				$time, e.data, e.last, d, last);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam int StallLimit = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0, s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid, m_tready = 1'b0, m_tlast;
	logic [31:0] m_tdata;

	sketch_scoreboard sb = new();
	int send_idle = 0, recv_stall = 0, sent = 0, quiet = 0;

	sobel_pencil_sketch_filter_top DUT (.*);

	always #5 clk = ~clk;

	always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall);

	always @(posedge clk) begin
		if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
		if (m_tvalid && m_tready) sb.check_output(m_tdata, m_tlast);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet = 0;
		else quiet++;
		if (quiet >= StallLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_item(bit drain, bit [31:0] d);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = drain;
		s_tdata  = d;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
		sent++;
	endtask

	task automatic drain_out();
		wait (sb.pending.size() == 0);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, bit [31:0] v);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = {idx, 2'b00}; pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		sb.set_reg(idx, v);
	endtask

	function automatic bit [31:0] rand_pixel(int style);
		bit [31:0] p;
		p = $urandom;
		case (style)
			0: p[23:0] = {3{p[7] ? 8'hFF : 8'h00}};
			1: p[23:0] = {3{8'd100 + p[1:0]}};
			default: ;
		endcase
		return p;
	endfunction

	task automatic send_frame(int style, int noise_pct);
		int unsigned total, w;
		w = sb.eff_w();
		total = w * sb.eff_h();
		for (int unsigned p = 0; p < total; p++) begin
			if ($urandom_range(99) < noise_pct) send_item(1'b1, $urandom);
			send_item(1'b0, rand_pixel(style));
		end
		for (int unsigned p = 0; p <= w; p++) begin
			if ($urandom_range(99) < noise_pct) send_item(1'b0, $urandom);
			send_item(1'b1, $urandom);
		end
	endtask

	initial begin
		int iter;
		bit [31:0] v;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_reg(REG_WIDTH, 3);
		write_reg(REG_HEIGHT, 3);
		write_reg(REG_THRESH, 0);
		write_reg(REG_DARK, 256);
		send_item(1'b1, 32'h0);
		send_item(1'b0, 32'h00000000);
		send_item(1'b0, 32'hFFFFFFFF);
		send_item(1'b0, 32'h00000000);
		send_item(1'b0, 32'hFFFFFFFF);
		send_item(1'b0, 32'h00FFFFFF);
		send_item(1'b0, 32'hFF000000);
		send_item(1'b0, 32'h000000FF);
		send_item(1'b0, 32'h0000FF00);
		send_item(1'b0, 32'h00FF0000);
		send_item(1'b0, 32'h12345678);
		repeat (4) send_item(1'b1, 32'hFFFFFFFF);
		drain_out();

		iter = 0;
		while (sent < 2000 || iter < 12) begin
			case (iter % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 75; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 75; end
				default: begin send_idle = 24; recv_stall = 24; end
			endcase
			drain_out();
			case (iter)
				3: begin write_reg(REG_WIDTH, 0); write_reg(REG_HEIGHT, 4095); end
				9: begin write_reg(REG_WIDTH, 0); write_reg(REG_HEIGHT, 0); end
				11: begin write_reg(REG_WIDTH, 40); write_reg(REG_HEIGHT, 3); end
				default: begin
					write_reg(REG_WIDTH, $urandom_range(1, 12));
					write_reg(REG_HEIGHT, $urandom_range(1, 8));
				end
			endcase
			case ($urandom_range(6))
				0: v = 0;
				1: v = 1;
				2: v = 256;
				3: v = 65280;
				4: v = 65535;
				default: v = $urandom_range(0, 65535);
			endcase
			write_reg(REG_THRESH, v);
			case ($urandom_range(4))
				0: v = 0;
				1: v = 256;
				2: v = 511;
				default: v = $urandom_range(0, 511);
			endcase
			write_reg(REG_DARK, v);
			if (iter % 5 == 4) begin
				repeat (40) send_item($urandom_range(1), $urandom);
			end else begin
				send_frame($urandom_range(2), (iter % 3 == 0) ? 10 : 0);
				if (iter % 2 && sb.eff_w() * sb.eff_h() <= 200)
					send_frame($urandom_range(2), 0);
			end
			iter++;
		end

		drain_out();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
